FILE: rtl/core/tml_pkg.sv
// Shared constants, types and helpers of the tile minimum locator.
`timescale 1ns / 1ps
`default_nettype none

package tml_pkg;

  localparam int unsigned PIX_W      = 16;
  localparam int unsigned TSZ_W      = 7;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CNT_W      = 10;
  localparam int unsigned OFF_W      = 6;
  localparam int unsigned TILE_MAX   = 64;
  localparam int unsigned DIM_MAX    = 1024;
  localparam int unsigned MEM_DEPTH  = 1024;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd3;

  localparam logic [TSZ_W-1:0]        TILE_SIZE_RST = 7'd8;
  localparam logic [DIM_W-1:0]        WIDTH_RST     = 11'd640;
  localparam logic [DIM_W-1:0]        HEIGHT_RST    = 11'd480;
  localparam logic signed [PIX_W-1:0] THRESH_RST    = 16'sd0;

  // position of the pixel being accepted, plus its tile boundary flags
  typedef struct packed {
    logic [CNT_W-1:0] tcol;
    logic [CNT_W-1:0] trow;
    logic [OFF_W-1:0] xo;
    logic [OFF_W-1:0] yo;
    logic             seg_first;
    logic             tile_first;
    logic             seg_last;
    logic             tile_done;
    logic             frame_last;
  } coord_t;

  // running minimum of one tile and where it sits
  typedef struct packed {
    logic signed [PIX_W-1:0] min_val;
    logic [OFF_W-1:0]        yo;
    logic [OFF_W-1:0]        xo;
  } entry_t;

  function automatic logic [TSZ_W-1:0] clamp_tile(input logic [TSZ_W-1:0] v);
    logic [TSZ_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = TSZ_W'(1);
    end else if (v > TSZ_W'(TILE_MAX)) begin
      r = TSZ_W'(TILE_MAX);
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(DIM_MAX)) begin
      r = DIM_W'(DIM_MAX);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tml_pix_if.sv
// Pixel input channel.
`timescale 1ns / 1ps
`default_nettype none

interface tml_pix_if;
  logic                             valid;
  logic                             ready;
  logic signed [tml_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tml_res_if.sv
// Per-tile result channel.
`timescale 1ns / 1ps
`default_nettype none

interface tml_res_if;
  logic                             valid;
  logic                             ready;
  logic [tml_pkg::CNT_W-1:0]        tile_column;
  logic [tml_pkg::CNT_W-1:0]        tile_row;
  logic [tml_pkg::OFF_W-1:0]        min_col_offset;
  logic [tml_pkg::OFF_W-1:0]        min_row_offset;
  logic signed [tml_pkg::PIX_W-1:0] min_value;
  logic                             marked;
  logic                             frame_done;

  modport source (output valid, output tile_column, output tile_row,
                  output min_col_offset, output min_row_offset, output min_value,
                  output marked, output frame_done, input ready);
  modport sink   (input valid, input tile_column, input tile_row,
                  input min_col_offset, input min_row_offset, input min_value,
                  input marked, input frame_done, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tml_raster.sv
// Raster position counters: pixel, tile and in-tile offset, kept in step.
`timescale 1ns / 1ps
`default_nettype none

module tml_raster (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        restart_i,
  input  wire logic                        adv_i,
  input  wire logic [tml_pkg::TSZ_W-1:0]   tile_size_i,
  input  wire logic [tml_pkg::DIM_W-1:0]   width_i,
  input  wire logic [tml_pkg::DIM_W-1:0]   height_i,
  output tml_pkg::coord_t                  coord_o
);

  logic [tml_pkg::CNT_W-1:0] x_q, x_d, y_q, y_d;
  logic [tml_pkg::CNT_W-1:0] tcol_q, tcol_d, trow_q, trow_d;
  logic [tml_pkg::OFF_W-1:0] xo_q, xo_d, yo_q, yo_d;
  logic col_end, row_end, xo_end, yo_end;

  assign col_end = (tml_pkg::DIM_W'(x_q) + tml_pkg::DIM_W'(1)) == width_i;
  assign row_end = (tml_pkg::DIM_W'(y_q) + tml_pkg::DIM_W'(1)) == height_i;
  assign xo_end  = (tml_pkg::TSZ_W'(xo_q) + tml_pkg::TSZ_W'(1)) == tile_size_i;
  assign yo_end  = (tml_pkg::TSZ_W'(yo_q) + tml_pkg::TSZ_W'(1)) == tile_size_i;

  always_comb begin
    coord_o.tcol       = tcol_q;
    coord_o.trow       = trow_q;
    coord_o.xo         = xo_q;
    coord_o.yo         = yo_q;
    coord_o.seg_first  = (xo_q == '0);
    coord_o.tile_first = (xo_q == '0) && (yo_q == '0);
    coord_o.seg_last   = xo_end || col_end;
    coord_o.tile_done  = (xo_end || col_end) && (yo_end || row_end);
    coord_o.frame_last = col_end && row_end;
  end

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    xo_d   = xo_q;
    yo_d   = yo_q;
    tcol_d = tcol_q;
    trow_d = trow_q;
    if (col_end) begin
      x_d    = '0;
      xo_d   = '0;
      tcol_d = '0;
      if (row_end) begin
        y_d    = '0;
        yo_d   = '0;
        trow_d = '0;
      end else begin
        y_d = y_q + tml_pkg::CNT_W'(1);
        if (yo_end) begin
          yo_d   = '0;
          trow_d = trow_q + tml_pkg::CNT_W'(1);
        end else begin
          yo_d = yo_q + tml_pkg::OFF_W'(1);
        end
      end
    end else begin
      x_d = x_q + tml_pkg::CNT_W'(1);
      if (xo_end) begin
        xo_d   = '0;
        tcol_d = tcol_q + tml_pkg::CNT_W'(1);
      end else begin
        xo_d = xo_q + tml_pkg::OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q    <= '0;
      y_q    <= '0;
      xo_q   <= '0;
      yo_q   <= '0;
      tcol_q <= '0;
      trow_q <= '0;
    end else if (restart_i) begin
      x_q    <= '0;
      y_q    <= '0;
      xo_q   <= '0;
      yo_q   <= '0;
      tcol_q <= '0;
      trow_q <= '0;
    end else if (adv_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      xo_q   <= xo_d;
      yo_q   <= yo_d;
      tcol_q <= tcol_d;
      trow_q <= trow_d;
    end
  end

`ifndef SYNTHESIS
  // frame wrap returns every counter to the origin
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && col_end && row_end |=>
      x_q == '0 && y_q == '0 && tcol_q == '0 && trow_q == '0 && xo_q == '0 && yo_q == '0)
    else $error("raster counters not cleared after last pixel of frame");

  a_offset_in_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tml_pkg::TSZ_W'(xo_q) < tile_size_i) && (tml_pkg::TSZ_W'(yo_q) < tile_size_i))
    else $error("in-tile offset ran past tile size");

  a_column_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !restart_i && !col_end |=> x_q == $past(x_q) + tml_pkg::CNT_W'(1))
    else $error("column counter did not step by one");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tml_min_track.sv
// Per-tile running minimum: pixel stage, tile-column store and result register.
`timescale 1ns / 1ps
`default_nettype none

module tml_min_track (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic signed [tml_pkg::PIX_W-1:0] pixel_i,
  input  wire tml_pkg::coord_t                  coord_i,
  input  wire logic signed [tml_pkg::PIX_W-1:0] threshold_i,
  output logic                                  in_ready_o,
  tml_res_if.source                             res
);

  // running minimum per tile column, carried from one pixel row to the next
  tml_pkg::entry_t tile_mem_q [tml_pkg::MEM_DEPTH];

  logic                             s1_valid_q;
  tml_pkg::coord_t                  s1_q;
  logic signed [tml_pkg::PIX_W-1:0] s1_px_q;
  tml_pkg::entry_t                  rd_q;
  tml_pkg::entry_t                  acc_q;
  tml_pkg::entry_t                  base, cand, upd;

  logic                             out_valid_q;
  logic [tml_pkg::CNT_W-1:0]        out_tcol_q, out_trow_q;
  logic [tml_pkg::OFF_W-1:0]        out_xo_q, out_yo_q;
  logic signed [tml_pkg::PIX_W-1:0] out_min_q;
  logic                             out_mark_q, out_frame_q;

  logic out_free, s1_go, in_fire, wr_en, res_load;

  assign out_free   = !out_valid_q || res.ready;
  assign s1_go      = s1_valid_q && (!s1_q.tile_done || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;
  assign wr_en      = s1_go && s1_q.seg_last;
  assign res_load   = s1_go && s1_q.tile_done;

  // first pixel of a row segment picks up the stored value of its tile column
  always_comb begin
    base         = s1_q.seg_first ? rd_q : acc_q;
    cand.min_val = s1_px_q;
    cand.yo      = s1_q.yo;
    cand.xo      = s1_q.xo;
    upd          = (s1_q.tile_first || (s1_px_q < base.min_val)) ? cand : base;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tile_mem_q[s1_q.tcol] <= upd;
    end
    if (in_fire) begin
      // write-through when the column just written is read again at once
      if (wr_en && (s1_q.tcol == coord_i.tcol)) begin
        rd_q <= upd;
      end else begin
        rd_q <= tile_mem_q[coord_i.tcol];
      end
      s1_q    <= coord_i;
      s1_px_q <= pixel_i;
    end
    if (s1_go) begin
      acc_q <= upd;
    end
    if (res_load) begin
      out_tcol_q  <= s1_q.tcol;
      out_trow_q  <= s1_q.trow;
      out_xo_q    <= upd.xo;
      out_yo_q    <= upd.yo;
      out_min_q   <= upd.min_val;
      out_mark_q  <= upd.min_val < threshold_i;
      out_frame_q <= s1_q.frame_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (res.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res.valid          = out_valid_q;
  assign res.tile_column    = out_tcol_q;
  assign res.tile_row       = out_trow_q;
  assign res.min_col_offset = out_xo_q;
  assign res.min_row_offset = out_yo_q;
  assign res.min_value      = out_min_q;
  assign res.marked         = out_mark_q;
  assign res.frame_done     = out_frame_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res.ready |-> !res_load)
    else $error("pending result word overwritten");

  a_tile_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_q)
    else $error("completed tile produced no result word");

  a_tile_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_q.tile_first |=> acc_q.min_val == $past(s1_px_q))
    else $error("first pixel of tile did not seed the minimum");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("empty pixel stage refused a word");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tile_minimum_locator_unit.sv
// Tile minimum locator top level: configuration registers, raster counters, min tracker.
//
//   channel  dir  word                                   handshake
//   pix_i    in   pixel (16b signed, raster order)       valid/ready
//   res_o    out  tile col/row, min offsets/value, flags valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i                  cfg_we_i, no stall
//
// One pixel is taken every clock unless a finished tile waits on a stalled result;
// a tile's result reaches the outputs via the pixel stage, then the result register.
// The tile-column store is one memory read at accept and written from the
// pixel stage, with a write-through for back-to-back use of one column.
// Reset or any register write restarts the frame at its first pixel.
// A stalled result only holds the input while a further tile completes.
`timescale 1ns / 1ps
`default_nettype none

module tile_minimum_locator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [tml_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [tml_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tml_pix_if.sink                                pix_i,
  tml_res_if.source                              res_o
);

  logic [tml_pkg::TSZ_W-1:0]        tile_size_q;
  logic [tml_pkg::DIM_W-1:0]        width_q, height_q;
  logic signed [tml_pkg::PIX_W-1:0] thresh_q;

  logic [tml_pkg::TSZ_W-1:0] tile_eff;
  logic [tml_pkg::DIM_W-1:0] width_eff, height_eff;
  tml_pkg::coord_t           coord;
  logic                      in_rdy, in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q <= tml_pkg::TILE_SIZE_RST;
      width_q     <= tml_pkg::WIDTH_RST;
      height_q    <= tml_pkg::HEIGHT_RST;
      thresh_q    <= tml_pkg::THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tml_pkg::CFG_TILE_SIZE:    tile_size_q <= cfg_data_i[tml_pkg::TSZ_W-1:0];
        tml_pkg::CFG_IMAGE_WIDTH:  width_q     <= cfg_data_i[tml_pkg::DIM_W-1:0];
        tml_pkg::CFG_IMAGE_HEIGHT: height_q    <= cfg_data_i[tml_pkg::DIM_W-1:0];
        tml_pkg::CFG_THRESHOLD:    thresh_q    <= cfg_data_i[tml_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign tile_eff   = tml_pkg::clamp_tile(tile_size_q);
  assign width_eff  = tml_pkg::clamp_dim(width_q);
  assign height_eff = tml_pkg::clamp_dim(height_q);

  assign pix_i.ready = in_rdy;
  assign in_fire     = pix_i.valid && in_rdy;

  tml_raster u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .adv_i       (in_fire),
    .tile_size_i (tile_eff),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .coord_o     (coord)
  );

  tml_min_track u_min_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pix_i.valid),
    .pixel_i     (pix_i.pixel),
    .coord_i     (coord),
    .threshold_i (thresh_q),
    .in_ready_o  (in_rdy),
    .res         (res_o)
  );

endmodule

`default_nettype wire
